@@ rtl/core/ptpd_pkg.sv @@
// Shared types and constants for the point transform with perspective divide.
// No dependencies; used by ptpd_divider and the top level.
`default_nettype none
package ptpd_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int IDX_W    = 4;
    localparam int FIELD_W  = 32;

    localparam logic [REG_W-1:0] M_ROW0_COLS01_RST = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] M_ROW0_COLS23_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] M_ROW1_COLS01_RST = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] M_ROW1_COLS23_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] M_ROW2_COLS01_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] M_ROW2_COLS23_RST = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] M_ROW3_COLS01_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] M_ROW3_COLS23_RST = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic w_zero;
        logic overflow;
    } ptpd_flags_t;

endpackage
`default_nettype wire

@@ rtl/core/ptpd_mac.sv @@
// Matrix multiply stages: twelve registered products, then four column sums.
// Does not use ptpd_pkg; two register stages.
`default_nettype none
module ptpd_mac #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int SW = 66
) (
    input  wire logic                         clk,
    input  wire logic                         adv,
    input  wire logic [2:0][CW-1:0]           pt,
    input  wire logic [3:0][3:0][CW-1:0]      mat,
    output logic      [3:0][SW-1:0]           acc
);

    logic [3:0][2:0][2*CW-1:0] prod_reg;
    logic [3:0][CW-1:0]        tr_reg;
    logic [3:0][SW-1:0]        acc_reg;
    logic [3:0][SW-1:0]        acc_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 3; r++)
                    prod_reg[c][r] <= $signed(pt[r]) * $signed(mat[r][c]);
                tr_reg[c] <= mat[3][c];
            end
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc_next[c] = {{(SW-CW-FB){tr_reg[c][CW-1]}}, tr_reg[c], {FB{1'b0}}};
            for (int r = 0; r < 3; r++)
                acc_next[c] = acc_next[c]
                    + {{(SW-2*CW){prod_reg[c][r][2*CW-1]}}, prod_reg[c][r]};
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

@@ rtl/core/ptpd_divider.sv @@
// Pipelined signed fixed-point divide with saturation, one quotient bit a stage.
// Depends on ptpd_pkg for the flag struct and the field width.
`default_nettype none
module ptpd_divider #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int SW = 66
) (
    input  wire logic                       clk,
    input  wire logic                       adv,
    input  wire logic [SW-1:0]              p,
    input  wire logic [SW-1:0]              w,
    output logic      [ptpd_pkg::FIELD_W-1:0] q,
    output ptpd_pkg::ptpd_flags_t           flags
);

    localparam int NW = SW + CW + FB;
    localparam logic [CW:0] LIM_POS = {2'b00, {(CW-1){1'b1}}};
    localparam logic [CW:0] LIM_NEG = {2'b01, {(CW-1){1'b0}}};

    logic [NW-1:0] n0_reg, d0_reg;
    logic          neg0_reg, wz0_reg;

    logic [NW-1:0] rem_reg [CW+1];
    logic [NW-1:0] d_reg   [CW+1];
    logic [CW-1:0] qt_reg  [CW+1];
    logic          neg_reg [CW+1];
    logic          wz_reg  [CW+1];
    logic          big_reg [CW+1];

    logic [ptpd_pkg::FIELD_W-1:0] q_reg, q_next;
    ptpd_pkg::ptpd_flags_t        flags_reg, flags_next;

    logic [SW-1:0] pm, wm;
    logic [CW:0]   qe, mag;
    logic [CW-1:0] res;

    assign pm = p[SW-1] ? (~p + 1'b1) : p;
    assign wm = w[SW-1] ? (~w + 1'b1) : w;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n0_reg   <= {{(CW){1'b0}}, pm, {FB{1'b0}}};
            d0_reg   <= {{(CW+FB){1'b0}}, wm};
            neg0_reg <= p[SW-1] ^ w[SW-1];
            wz0_reg  <= (w == '0);

            rem_reg[0] <= n0_reg;
            d_reg[0]   <= d0_reg;
            qt_reg[0]  <= '0;
            neg_reg[0] <= neg0_reg;
            wz_reg[0]  <= wz0_reg;
            big_reg[0] <= n0_reg >= (d0_reg << CW);

            for (int k = 0; k < CW; k++)
            begin
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                wz_reg[k+1]  <= wz_reg[k];
                big_reg[k+1] <= big_reg[k];
                if (rem_reg[k] >= (d_reg[k] << (CW-1-k)))
                begin
                    rem_reg[k+1] <= rem_reg[k] - (d_reg[k] << (CW-1-k));
                    qt_reg[k+1]  <= qt_reg[k] | (CW'(1) << (CW-1-k));
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    qt_reg[k+1]  <= qt_reg[k];
                end
            end

            q_reg     <= q_next;
            flags_reg <= flags_next;
        end
    end

    always_comb
    begin
        qe = {1'b0, qt_reg[CW]};
        flags_next.w_zero   = wz_reg[CW];
        flags_next.overflow = 1'b0;
        if (neg_reg[CW])
        begin
            if (big_reg[CW] || (qe > LIM_NEG))
            begin
                mag = LIM_NEG;
                flags_next.overflow = 1'b1;
            end
            else
                mag = qe;
            res = CW'(~mag + 1'b1);
        end
        else
        begin
            if (big_reg[CW] || (qe > LIM_POS))
            begin
                mag = LIM_POS;
                flags_next.overflow = 1'b1;
            end
            else
                mag = qe;
            res = mag[CW-1:0];
        end
        if (wz_reg[CW])
        begin
            res = '0;
            flags_next.overflow = 1'b0;
        end
        q_next = {{(ptpd_pkg::FIELD_W-CW){res[CW-1]}}, res};
    end

    assign q     = q_reg;
    assign flags = flags_reg;

endmodule
`default_nettype wire

@@ rtl/core/point_transform_perspective_divide.sv @@
// Top level: 4x4 homogeneous point transform followed by perspective divide.
// Depends on ptpd_pkg, ptpd_mac and ptpd_divider.
//
//  group  | dir | width      | contents (lowest bit up)
//  s_axis | in  | tdata 96   | pt_x, pt_y, pt_z
//  m_axis | out | tdata 96   | out_x, out_y, out_z ; tuser 2: w_zero, overflow
//  cfg    | in  | idx 4, 64  | matrix register write, index 0..7
//
// One item per cycle while the output is not stalled; two multiply/sum stages,
// two divide set-up stages, one stage per quotient bit, one output stage.
// All stages advance together whenever the output register is empty or taken.
// Reset clears valid bits and loads the identity matrix.
`default_nettype none
module point_transform_perspective_divide #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [95:0]                   s_tdata,   // pt_x, pt_y, pt_z
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [95:0]                        m_tdata,   // out_x, out_y, out_z
    output logic [1:0]                         m_tuser,   // w_zero, overflow
    input  wire logic                          cfg_we,
    input  wire logic [ptpd_pkg::IDX_W-1:0]    cfg_idx,
    input  wire logic [ptpd_pkg::REG_W-1:0]    cfg_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int SW  = ((2*CW > CW+FB) ? 2*CW : CW+FB) + 2;
    localparam int LAT = CW + 5;

    logic [ptpd_pkg::REG_W-1:0] mreg_reg [ptpd_pkg::NUM_REGS];
    logic [LAT-1:0]             vld_reg;
    logic                       adv;

    logic [2:0][CW-1:0]      pt;
    logic [3:0][3:0][CW-1:0] mat;
    logic [3:0][SW-1:0]      acc;
    logic [2:0][ptpd_pkg::FIELD_W-1:0] qv;
    ptpd_pkg::ptpd_flags_t   fl [3];

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mreg_reg[0] <= ptpd_pkg::M_ROW0_COLS01_RST;
            mreg_reg[1] <= ptpd_pkg::M_ROW0_COLS23_RST;
            mreg_reg[2] <= ptpd_pkg::M_ROW1_COLS01_RST;
            mreg_reg[3] <= ptpd_pkg::M_ROW1_COLS23_RST;
            mreg_reg[4] <= ptpd_pkg::M_ROW2_COLS01_RST;
            mreg_reg[5] <= ptpd_pkg::M_ROW2_COLS23_RST;
            mreg_reg[6] <= ptpd_pkg::M_ROW3_COLS01_RST;
            mreg_reg[7] <= ptpd_pkg::M_ROW3_COLS23_RST;
            vld_reg     <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_idx < ptpd_pkg::IDX_W'(ptpd_pkg::NUM_REGS)))
                mreg_reg[cfg_idx[2:0]] <= cfg_data;
            if (adv)
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            pt[r] = s_tdata[32*r +: CW];
        for (int r = 0; r < 4; r++)
        begin
            mat[r][0] = mreg_reg[2*r][CW-1:0];
            mat[r][1] = mreg_reg[2*r][32 +: CW];
            mat[r][2] = mreg_reg[2*r+1][CW-1:0];
            mat[r][3] = mreg_reg[2*r+1][32 +: CW];
        end
    end

    ptpd_mac #(.CW(CW), .FB(FB), .SW(SW)) u_mac (
        .clk (clk),
        .adv (adv),
        .pt  (pt),
        .mat (mat),
        .acc (acc)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        ptpd_divider #(.CW(CW), .FB(FB), .SW(SW)) u_div (
            .clk   (clk),
            .adv   (adv),
            .p     (acc[c]),
            .w     (acc[3]),
            .q     (qv[c]),
            .flags (fl[c])
        );
    end

    assign m_tdata = {qv[2], qv[1], qv[0]};
    assign m_tuser = {fl[0].overflow || fl[1].overflow || fl[2].overflow, fl[0].w_zero};

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stage");

    a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("zero w item carries data or overflow");

    a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_idx[3]) |=> ($stable(mreg_reg[0]) && $stable(mreg_reg[7])))
        else $error("write beyond register list changed matrix");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
